### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bcpid_pkg.sv
package bcpid_pkg;

    localparam int DRIVE_LIMIT_DEF = 900;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int IN_W       = 16;
    localparam int DRIVE_W    = 13;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_USED_W = 29;
    localparam int OUT_DATA_W = 32;

    localparam int OUT_RIGHT_LSB  = 13;
    localparam int OUT_OVER_BIT   = 26;
    localparam int OUT_TILT_BIT   = 27;
    localparam int OUT_PAUSED_BIT = 28;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_SEL         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GOAL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TURN_RATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_GOAL         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STAND_KP         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STAND_KD         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP         = 3'd7;

    localparam int OVERSPEED_LIMIT = 60;
    localparam int TILT_LIMIT_Q8   = 28 * 256;
    localparam int TURN_GAIN       = 100;
    localparam int TURN_LIMIT      = 500;
    localparam int TURN_W          = 10;
    localparam int POS_LIMIT       = 5;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_V = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_V = {1'b1, {(DRIVE_W-1){1'b0}}};

    typedef struct packed {
        logic               loop_sel;
        logic signed [15:0] target_angle;
        logic signed [15:0] speed_goal;
        logic signed [15:0] target_turn_rate;
        logic signed [15:0] pos_goal;
        logic signed [15:0] stand_kp;
        logic signed [15:0] stand_kd;
        logic signed [15:0] speed_kp;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        loop_sel:         1'b0,
        target_angle:     -16'sd845,
        speed_goal:       16'sd0,
        target_turn_rate: 16'sd0,
        pos_goal:         16'sd0,
        stand_kp:         16'sd105,
        stand_kd:         16'sd1000,
        speed_kp:         -16'sd50
    };

endpackage

### rtl/bcpid_cfg.sv
module bcpid_cfg
    import bcpid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                REG_LOOP_SEL:         n_cfg.loop_sel         = i_wr_data[0];
                REG_TARGET_ANGLE:     n_cfg.target_angle     = i_wr_data;
                REG_SPEED_GOAL:       n_cfg.speed_goal       = i_wr_data;
                REG_TARGET_TURN_RATE: n_cfg.target_turn_rate = i_wr_data;
                REG_POS_GOAL:         n_cfg.pos_goal         = i_wr_data;
                REG_STAND_KP:         n_cfg.stand_kp         = i_wr_data;
                REG_STAND_KD:         n_cfg.stand_kd         = i_wr_data;
                REG_SPEED_KP:         n_cfg.speed_kp         = i_wr_data;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/bcpid_mul.sv
module bcpid_mul
    import bcpid_pkg::*;
#(
    parameter int A_W = 18,
    parameter int B_W = 16
) (
    input  logic                        i_clk,
    input  logic signed [A_W-1:0]       i_a,
    input  logic signed [B_W-1:0]       i_b,
    output logic signed [A_W+B_W-1:0]   o_p
);

    logic signed [A_W-1:0]     r_a;
    logic signed [B_W-1:0]     r_b;
    logic signed [A_W+B_W-1:0] r_p;

    // operands registered, product registered
    always_ff @(posedge i_clk) begin
        r_a <= i_a;
        r_b <= i_b;
        r_p <= r_a * r_b;
    end

    assign o_p = r_p;

endmodule

### rtl/balance_car_cascade_pid_core.sv
// Cascaded balance controller: upright PD, speed P (or position P feeding it) and turn P.
// Input stream: one item per control tick, tilt and both wheel encoder counts.
// Output stream: one item per input item, both wheel drive commands and fault flags.
// Config channel: register index and 16-bit data, always ready; write only while idle.
// Every product goes through one shared two-stage multiplier under a 15-state sequencer.
// s_axis_tready is high only in the idle state, and the result is loaded into the
// output register from the last state, once the sequencer has stepped through the rest.
// A new input item is not taken before the last one is finished, since the six multiplies
// are issued in turn to the shared multiplier, followed by the clamp and sum steps.
// The output register holds a finished item while the next input item is taken;
// if the receiver stalls, the sequencer waits in its last state until the output
// register is free, and s_axis_tready stays low meanwhile.
// Reset (synchronous, active low) restores all config registers to their defaults,
// clears wheel position, previous tilt error and the pause latch, and drops
// m_axis_tvalid.
`include "assert_macros.svh"

module balance_car_cascade_pid_core
    import bcpid_pkg::*;
#(
    parameter int DRIVE_LIMIT = DRIVE_LIMIT_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tilt_angle[15:0], left_speed[31:16], right_speed[47:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // left_drive[12:0], right_drive[25:13], overspeed[26], tilt_fault[27],
    // paused[28], zero[31:29]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int MA_W  = (FRAC_BITS + 1 > 18) ? FRAC_BITS + 1 : 18;
    localparam int MB_W  = (FRAC_BITS - 5 > 16) ? FRAC_BITS - 5 : 16;
    localparam int MP_W  = MA_W + MB_W;
    localparam int ACC_W = (FRAC_BITS + 18 > 35) ? FRAC_BITS + 18 : 35;
    localparam int U2_W  = FRAC_BITS + 34;
    localparam int SPD_W = FRAC_BITS + 16;
    localparam int Q_W   = ACC_W - FRAC_BITS;

    localparam longint UNIT_FX = longint'(1) <<< FRAC_BITS;

    localparam logic signed [MB_W-1:0]  POS_GAIN  = MB_W'((UNIT_FX + 50) / 100);
    localparam logic signed [MB_W-1:0]  TURN_G_B  = MB_W'(TURN_GAIN);
    localparam logic signed [ACC_W-1:0] LIM_Q8    = ACC_W'(longint'(DRIVE_LIMIT) * 256);
    localparam logic signed [ACC_W-1:0] NLIM_Q8   = -LIM_Q8;
    localparam logic signed [U2_W-1:0]  LIM_FX    = U2_W'(longint'(DRIVE_LIMIT) * UNIT_FX);
    localparam logic signed [U2_W-1:0]  NLIM_FX   = -LIM_FX;
    localparam logic signed [MP_W-1:0]  TURN_LIM  = MP_W'(TURN_LIMIT);
    localparam logic signed [MP_W-1:0]  NTURN_LIM = -TURN_LIM;
    localparam logic signed [MP_W-1:0]  POS_LIM   = MP_W'(longint'(POS_LIMIT) * UNIT_FX);
    localparam logic signed [MP_W-1:0]  NPOS_LIM  = -POS_LIM;
    localparam logic signed [Q_W-1:0]   DRV_MAX_Q = Q_W'(DRIVE_MAX_V);
    localparam logic signed [Q_W-1:0]   DRV_MIN_Q = Q_W'(DRIVE_MIN_V);
    localparam logic signed [IN_W-1:0]  OVER_LIM  = IN_W'(OVERSPEED_LIMIT);
    localparam logic signed [IN_W-1:0]  NOVER_LIM = -OVER_LIM;
    localparam logic signed [IN_W-1:0]  TILT_LIM  = IN_W'(TILT_LIMIT_Q8);
    localparam logic signed [IN_W-1:0]  NTILT_LIM = -TILT_LIM;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_ISSUE_KP   = 4'd1;
    localparam logic [3:0] ST_ISSUE_KD   = 4'd2;
    localparam logic [3:0] ST_ISSUE_TURN = 4'd3;
    localparam logic [3:0] ST_ISSUE_POS  = 4'd4;
    localparam logic [3:0] ST_CLAMP_U1   = 4'd5;
    localparam logic [3:0] ST_SPD_TGT    = 4'd6;
    localparam logic [3:0] ST_ISSUE_DH   = 4'd7;
    localparam logic [3:0] ST_ISSUE_DL   = 4'd8;
    localparam logic [3:0] ST_U2_HI      = 4'd9;
    localparam logic [3:0] ST_U2_LO      = 4'd10;
    localparam logic [3:0] ST_CLAMP_U2   = 4'd11;
    localparam logic [3:0] ST_ADD_U2     = 4'd12;
    localparam logic [3:0] ST_WHEEL      = 4'd13;
    localparam logic [3:0] ST_OUT        = 4'd14;

    t_cfg cfg;

    logic [3:0] r_state, n_state;
    logic signed [IN_W-1:0] r_tilt, r_ls, r_rs;
    logic signed [IN_W-1:0] r_pos, n_pos;
    logic signed [17:0] r_prev, n_prev;
    logic r_pause, n_pause;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [TURN_W-1:0] r_u3, n_u3;
    logic signed [SPD_W-1:0] r_spd, n_spd;
    logic signed [U2_W-1:0] r_u2, n_u2;
    logic signed [ACC_W-1:0] r_sl, n_sl, r_sr, n_sr;
    logic r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data, n_m_data;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;

    logic signed [16:0] sum_lr, avg_t, err, pos_err, dh;
    logic signed [IN_W-1:0] avg, spd_hi;
    logic signed [17:0] err_w, diff, turn_d;
    logic over, tfault, in_take, out_free;
    logic out_paused, u2_in_lim;

    logic signed [ACC_W-1:0] u1_sat, u1_fx, u2_acc, u3_fx, bias_l, bias_r, t_l, t_r;
    logic signed [MP_W-1:0] u3_sat, spd_sat;
    logic signed [U2_W-1:0] p_ext, u2_sat;
    logic signed [SPD_W-1:0] ts_fx;
    logic [FRAC_BITS-1:0] dl;
    logic signed [Q_W-1:0] q_l, q_r;
    logic signed [DRIVE_W-1:0] drv_l, drv_r;

    bcpid_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    bcpid_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_take       = s_axis_tvalid & s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    // per-tick terms from the held input item
    assign sum_lr  = 17'(r_ls) + 17'(r_rs);
    assign avg_t   = sum_lr + 17'(sum_lr[16]);
    assign avg     = avg_t[16:1];
    assign err     = 17'(cfg.target_angle) - 17'(r_tilt);
    assign err_w   = 18'(err);
    assign diff    = err_w - r_prev;
    assign turn_d  = 18'(cfg.target_turn_rate) - (18'(r_ls) - 18'(r_rs));
    assign pos_err = 17'(cfg.pos_goal) - 17'(r_pos);
    assign over    = (r_ls > OVER_LIM) || (r_ls < NOVER_LIM)
                  || (r_rs > OVER_LIM) || (r_rs < NOVER_LIM);
    assign tfault  = (r_tilt > TILT_LIM) || (r_tilt < NTILT_LIM);

    // clamps and scaling
    assign u1_sat  = (r_acc > LIM_Q8) ? LIM_Q8 : ((r_acc < NLIM_Q8) ? NLIM_Q8 : r_acc);
    assign u1_fx   = u1_sat <<< (FRAC_BITS - 8);
    assign u3_sat  = (mul_p > TURN_LIM) ? TURN_LIM : ((mul_p < NTURN_LIM) ? NTURN_LIM : mul_p);
    assign spd_sat = (mul_p > POS_LIM) ? POS_LIM : ((mul_p < NPOS_LIM) ? NPOS_LIM : mul_p);
    assign ts_fx   = {cfg.speed_goal, {FRAC_BITS{1'b0}}};

    // split speed error into whole counts and fraction
    assign spd_hi  = r_spd[SPD_W-1:FRAC_BITS];
    assign dh      = 17'(spd_hi) - 17'(avg);
    assign dl      = r_spd[FRAC_BITS-1:0];

    assign p_ext   = U2_W'(mul_p);
    assign u2_sat  = (r_u2 > LIM_FX) ? LIM_FX : ((r_u2 < NLIM_FX) ? NLIM_FX : r_u2);
    assign u2_acc  = r_u2[ACC_W-1:0];
    assign u3_fx   = ACC_W'(r_u3) <<< FRAC_BITS;

    // truncate toward zero: bias negative sums before dropping the fraction
    assign bias_l  = ACC_W'({FRAC_BITS{r_sl[ACC_W-1]}});
    assign bias_r  = ACC_W'({FRAC_BITS{r_sr[ACC_W-1]}});
    assign t_l     = r_sl + bias_l;
    assign t_r     = r_sr + bias_r;
    assign q_l     = t_l[ACC_W-1:FRAC_BITS];
    assign q_r     = t_r[ACC_W-1:FRAC_BITS];
    assign drv_l   = (q_l > DRV_MAX_Q) ? DRIVE_MAX_V
                   : ((q_l < DRV_MIN_Q) ? DRIVE_MIN_V : q_l[DRIVE_W-1:0]);
    assign drv_r   = (q_r > DRV_MAX_Q) ? DRIVE_MAX_V
                   : ((q_r < DRV_MIN_Q) ? DRIVE_MIN_V : q_r[DRIVE_W-1:0]);

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_prev    = r_prev;
        n_pause   = r_pause;
        n_acc     = r_acc;
        n_u3      = r_u3;
        n_spd     = r_spd;
        n_u2      = r_u2;
        n_sl      = r_sl;
        n_sr      = r_sr;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        mul_a     = '0;
        mul_b     = '0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_ISSUE_KP;
                end
            end
            ST_ISSUE_KP: begin
                mul_a   = MA_W'(err);
                mul_b   = MB_W'(cfg.stand_kp);
                n_pos   = r_pos + avg;
                n_pause = r_pause | over | tfault;
                n_state = ST_ISSUE_KD;
            end
            ST_ISSUE_KD: begin
                mul_a   = MA_W'(diff);
                mul_b   = MB_W'(cfg.stand_kd);
                n_prev  = err_w;
                n_state = ST_ISSUE_TURN;
            end
            ST_ISSUE_TURN: begin
                mul_a   = MA_W'(turn_d);
                mul_b   = TURN_G_B;
                n_acc   = ACC_W'(mul_p);
                n_state = ST_ISSUE_POS;
            end
            ST_ISSUE_POS: begin
                mul_a   = MA_W'(pos_err);
                mul_b   = POS_GAIN;
                n_acc   = r_acc + ACC_W'(mul_p);
                n_state = ST_CLAMP_U1;
            end
            ST_CLAMP_U1: begin
                n_acc   = u1_fx;
                n_u3    = u3_sat[TURN_W-1:0];
                n_state = ST_SPD_TGT;
            end
            ST_SPD_TGT: begin
                n_spd   = cfg.loop_sel ? spd_sat[SPD_W-1:0] : ts_fx;
                n_state = ST_ISSUE_DH;
            end
            ST_ISSUE_DH: begin
                mul_a   = MA_W'(dh);
                mul_b   = MB_W'(cfg.speed_kp);
                n_state = ST_ISSUE_DL;
            end
            ST_ISSUE_DL: begin
                mul_a   = MA_W'(dl);
                mul_b   = MB_W'(cfg.speed_kp);
                n_state = ST_U2_HI;
            end
            ST_U2_HI: begin
                n_u2    = p_ext <<< FRAC_BITS;
                n_state = ST_U2_LO;
            end
            ST_U2_LO: begin
                n_u2    = r_u2 + p_ext;
                n_state = ST_CLAMP_U2;
            end
            ST_CLAMP_U2: begin
                n_u2    = u2_sat;
                n_state = ST_ADD_U2;
            end
            ST_ADD_U2: begin
                n_acc   = r_acc + u2_acc;
                n_state = ST_WHEEL;
            end
            ST_WHEEL: begin
                n_sl    = r_acc + u3_fx;
                n_sr    = r_acc - u3_fx;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, r_pause, tfault, over,
                                 drv_r, drv_l};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_prev    <= '0;
            r_pause   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_prev    <= n_prev;
            r_pause   <= n_pause;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_tilt <= s_axis_tdata[15:0];
            r_ls   <= s_axis_tdata[31:16];
            r_rs   <= s_axis_tdata[47:32];
        end
        r_acc    <= n_acc;
        r_u3     <= n_u3;
        r_spd    <= n_spd;
        r_u2     <= n_u2;
        r_sl     <= n_sl;
        r_sr     <= n_sr;
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign out_paused = r_m_valid && r_m_data[OUT_PAUSED_BIT];
    assign u2_in_lim  = (r_u2 <= LIM_FX) && (r_u2 >= NLIM_FX);

    `CHK_NEXT(a_pause_sticky, i_clk, i_rst_n, r_pause, r_pause, "pause latch cleared")
    `CHK_SAME(a_paused_flag, i_clk, i_rst_n, out_paused, r_pause, "paused flag without latch")
    `CHK_NEXT(a_busy_after_take, i_clk, i_rst_n, in_take, !s_axis_tready, "ready after take")
    `CHK_SAME(a_u2_bounded, i_clk, i_rst_n, r_state == ST_ADD_U2, u2_in_lim, "speed term too big")

endmodule
